>>> rtl/lgbe_pkg.sv
`default_nettype none

package lgbe_pkg;

   localparam int OP_W    = 3;
   localparam int DATA_W  = 8;
   localparam int POS_W   = 8;
   localparam int SHIFT_W = 10;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_DELETE = 3'd1,
      OP_LEFT   = 3'd2,
      OP_RIGHT  = 3'd3,
      OP_MOVE   = 3'd4,
      OP_START  = 3'd5,
      OP_END    = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_STEP_CHK,
      ST_STEP_WR,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request word, set up walk
      logic ins;       // write char at gap_first, advance
      logic del;       // drop cursor char
      logic set_fail;  // mark result refused
      logic step_rd;   // read the character that crosses the gap
      logic step_wr;   // write it on the far side, move both pointers
      logic fetch_rd;  // read the cursor character
      logic emit;      // load the result register
   } lgbe_cmd_type;

   // datapath -> controller
   typedef struct packed {
      opcode_type op;
      logic       full;
      logic       gap_first_zero;
      logic       can_dir;
      logic       can_step;
      logic       out_free;
   } lgbe_stat_type;

endpackage

`default_nettype wire

>>> rtl/lgbe_ram.sv
`default_nettype none

module lgbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/lgbe_ctrl.sv
`default_nettype none

module lgbe_ctrl import lgbe_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire lgbe_stat_type stat,
   output lgbe_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.op)
               OP_INSERT: begin
                  if (stat.full) begin
                     cmd.set_fail = 1'b1;
                  end else begin
                     cmd.ins = 1'b1;
                  end
                  state_in = ST_FETCH;
               end
               OP_DELETE: begin
                  if (stat.gap_first_zero) begin
                     cmd.set_fail = 1'b1;
                     state_in     = ST_FETCH;
                  end else begin
                     cmd.del  = 1'b1;
                     state_in = ST_STEP_CHK;
                  end
               end
               OP_LEFT, OP_RIGHT: begin
                  if (stat.can_dir) begin
                     state_in = ST_STEP_CHK;
                  end else begin
                     cmd.set_fail = 1'b1;
                     state_in     = ST_FETCH;
                  end
               end
               OP_MOVE, OP_START, OP_END: begin
                  state_in = ST_STEP_CHK;
               end
               default: begin
                  cmd.set_fail = 1'b1;
                  state_in     = ST_FETCH;
               end
            endcase
         end
         ST_STEP_CHK: begin
            if (stat.can_step) begin
               cmd.step_rd = 1'b1;
               state_in    = ST_STEP_WR;
            end else begin
               cmd.fetch_rd = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_STEP_WR: begin
            cmd.step_wr = 1'b1;
            state_in    = ST_STEP_CHK;
         end
         ST_FETCH: begin
            cmd.fetch_rd = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/lgbe_dp.sv
`default_nettype none

module lgbe_dp import lgbe_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lgbe_cmd_type              cmd,
   output lgbe_stat_type                  stat,
   input  wire logic        [OP_W-1:0]    req_operation,
   input  wire logic        [DATA_W-1:0]  req_char_in,
   input  wire logic signed [SHIFT_W-1:0] req_shift_amount,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_status,
   output logic             [POS_W-1:0]   rsp_cursor_pos,
   output logic             [POS_W-1:0]   rsp_text_length,
   output logic             [DATA_W-1:0]  rsp_cursor_char
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int PW = (AW + 1 > POS_W) ? AW + 1 : POS_W;
   localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);
   localparam logic [AW-1:0] ONE  = AW'(1);

   logic [AW-1:0]      gap_first_ff, gap_first_in;
   logic [AW-1:0]      gap_last_ff, gap_last_in;
   opcode_type         op_ff;
   logic [DATA_W-1:0]  char_ff;
   logic               dir_left_ff, dir_left_in;
   logic [SHIFT_W-1:0] count_ff, count_in;
   logic               unlimited_ff, unlimited_in;
   logic               fail_ff;
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [POS_W-1:0]   rsp_cursor_pos_ff;
   logic [POS_W-1:0]   rsp_text_length_ff;
   logic [DATA_W-1:0]  rsp_cursor_char_ff;

   logic               can_left, can_right, can_dir;
   logic [SHIFT_W-1:0] magnitude;
   logic [PW-1:0]      pos_wide, len_wide;
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [DATA_W-1:0]  wr_data, rd_data;

   assign can_left  = gap_first_ff > ONE;
   assign can_right = gap_last_ff != LAST;
   assign can_dir   = dir_left_ff ? can_left : can_right;
   assign magnitude = req_shift_amount[SHIFT_W-1] ?
                      (~req_shift_amount + SHIFT_W'(1)) : req_shift_amount;

   assign stat.op             = op_ff;
   assign stat.full           = gap_first_ff == gap_last_ff;
   assign stat.gap_first_zero = gap_first_ff == '0;
   assign stat.can_dir        = can_dir;
   assign stat.can_step       = can_dir && (unlimited_ff || count_ff != '0);
   assign stat.out_free       = !rsp_valid_ff || rsp_ready;

   // walk setup from the incoming word; count down on each bounded step
   always_comb begin
      dir_left_in  = dir_left_ff;
      count_in     = count_ff;
      unlimited_in = unlimited_ff;
      if (cmd.load) begin
         dir_left_in  = 1'b0;
         count_in     = '0;
         unlimited_in = 1'b0;
         unique case (opcode_type'(req_operation))
            OP_LEFT: begin
               dir_left_in = 1'b1;
               count_in    = SHIFT_W'(1);
            end
            OP_RIGHT, OP_DELETE: begin
               count_in = SHIFT_W'(1);
            end
            OP_MOVE: begin
               dir_left_in = req_shift_amount[SHIFT_W-1];
               count_in    = magnitude;
            end
            OP_START: begin
               dir_left_in  = 1'b1;
               unlimited_in = 1'b1;
            end
            OP_END: begin
               unlimited_in = 1'b1;
            end
            default: begin
               count_in = '0;
            end
         endcase
      end else if (cmd.step_wr && !unlimited_ff) begin
         count_in = count_ff - SHIFT_W'(1);
      end
   end

   always_comb begin
      gap_first_in = gap_first_ff;
      gap_last_in  = gap_last_ff;
      if (cmd.ins) begin
         gap_first_in = gap_first_ff + ONE;
      end else if (cmd.del) begin
         gap_first_in = gap_first_ff - ONE;
      end else if (cmd.step_wr) begin
         if (dir_left_ff) begin
            gap_first_in = gap_first_ff - ONE;
            gap_last_in  = gap_last_ff - ONE;
         end else begin
            gap_first_in = gap_first_ff + ONE;
            gap_last_in  = gap_last_ff + ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_first_ff <= '0;
         gap_last_ff  <= LAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         gap_first_ff <= gap_first_in;
         gap_last_ff  <= gap_last_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_left_ff  <= dir_left_in;
      count_ff     <= count_in;
      unlimited_ff <= unlimited_in;
      if (cmd.load) begin
         op_ff   <= opcode_type'(req_operation);
         char_ff <= req_char_in;
         fail_ff <= 1'b0;
      end else if (cmd.set_fail) begin
         fail_ff <= 1'b1;
      end
      if (cmd.emit) begin
         rsp_status_ff      <= fail_ff;
         rsp_cursor_pos_ff  <= pos_wide[POS_W-1:0];
         rsp_text_length_ff <= len_wide[POS_W-1:0];
         rsp_cursor_char_ff <= (gap_first_ff == '0) ? '0 : rd_data;
      end
   end

   assign pos_wide = PW'(gap_first_ff);
   assign len_wide = PW'(gap_first_ff) + PW'(LAST) - PW'(gap_last_ff);

   // store ports: inserts write the char; text crosses the gap through the read register
   assign wr_en   = cmd.ins || cmd.step_wr;
   assign wr_addr = (cmd.step_wr && dir_left_ff) ? gap_last_ff : gap_first_ff;
   assign wr_data = cmd.ins ? char_ff : rd_data;
   assign rd_en   = cmd.step_rd || cmd.fetch_rd;
   assign rd_addr = (cmd.step_rd && !dir_left_ff) ? gap_last_ff + ONE
                                                  : gap_first_ff - ONE;

   lgbe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_cursor_pos  = rsp_cursor_pos_ff;
   assign rsp_text_length = rsp_text_length_ff;
   assign rsp_cursor_char = rsp_cursor_char_ff;

endmodule

`default_nettype wire

>>> rtl/line_gap_buffer_editor.sv
// One-line text gap buffer editor.
// req_ channel: one edit command per word (operation, char_in, shift_amount),
// taken on req_valid && req_ready. rsp_ channel: exactly one word back per
// command, in order, with status, cursor_pos, text_length and cursor_char.
// Commands are handled one at a time; req_ready is high only while idle.
// Each command is decoded, walks the gap if it moves the cursor, then fetches
// the cursor char and loads the result. Insert, refused op, unknown op and
// delete with no right text walk no character; single steps (left, right,
// delete that pulls a char) walk one; move-by, start and end walk up to
// STORE_DEPTH characters. Each character crossing the gap takes one store
// read and one store write on the single-port-pair text RAM.
// The next command is taken at the earliest in the cycle after the result is
// loaded, so a command never starts before the last one is through.
// The result sits in an output register; the next command is accepted while
// it waits, and a stalled rsp_ready only holds the finishing command in its
// last state until the register frees up.
// Reset (synchronous, active high) empties the text at once: cursor 0,
// gap spanning the whole store; no store sweep is run, since a slot is
// always written before it joins the text.
`default_nettype none

module line_gap_buffer_editor import lgbe_pkg::*; #(
   parameter int STORE_DEPTH = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic        [OP_W-1:0]    req_operation,
   input  wire logic        [DATA_W-1:0]  req_char_in,
   input  wire logic signed [SHIFT_W-1:0] req_shift_amount,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_status,
   output logic             [POS_W-1:0]   rsp_cursor_pos,
   output logic             [POS_W-1:0]   rsp_text_length,
   output logic             [DATA_W-1:0]  rsp_cursor_char
);

   lgbe_cmd_type  cmd;
   lgbe_stat_type stat;

   // sequencing: decode, gap walk loop, cursor char fetch, result hand-off
   lgbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // gap pointers, walk counter, text store and result register
   lgbe_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_char_in      (req_char_in),
      .req_shift_amount (req_shift_amount),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .rsp_text_length  (rsp_text_length),
      .rsp_cursor_char  (rsp_cursor_char)
   );

endmodule

`default_nettype wire
